// ===== hw/rtl/svi_pkg.sv =====
`default_nettype none

package svi_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int FRAC_W    = 14;
    localparam int RATIO_W   = 24;
    localparam int NDQ_W     = FRAC_W + 1;
    localparam int ROOT_W    = 15;
    localparam int SQV_W     = 2 * ROOT_W;

    // stage map: [0] capture, [1..15] ndvi divide, [1..24] ratio divide,
    // [16] ndvi/half-offset, [17..31] square root
    localparam int ND_FIRST   = 1;
    localparam int ND_LAST    = ND_FIRST + NDQ_W - 1;
    localparam int RT_LAST    = ND_FIRST + RATIO_W - 1;
    localparam int NDVI_STAGE = ND_LAST + 1;
    localparam int SQ_FIRST   = NDVI_STAGE + 1;
    localparam int SQ_LAST    = SQ_FIRST + ROOT_W - 1;
    localparam int NUM_STAGES = SQ_LAST + 1;

    localparam logic signed [SAMPLE_W:0] FRAC_HALF = 17'sd8192;

    typedef struct packed {
        logic                      valid;
        logic                      both_zero;
        logic                      red_zero;
        logic                      nir_zero;
        logic                      nd_neg;
        logic [SAMPLE_W:0]         nd_den;
        logic [SAMPLE_W+1:0]       nd_rem;
        logic [NDQ_W-1:0]          nd_q;
        logic [SAMPLE_W-1:0]       rt_den;
        logic [RATIO_W-1:0]        rt_num;
        logic [SAMPLE_W:0]         rt_rem;
        logic [RATIO_W-1:0]        rt_q;
        logic signed [SAMPLE_W-1:0] ndvi;
        logic                      h_neg;
        logic                      h_le0;
        logic [SQV_W-1:0]          sq_v;
        logic [SAMPLE_W+1:0]       sq_rem;
        logic [ROOT_W-1:0]         sq_root;
    } stage_t;

endpackage

`default_nettype wire

// ===== hw/rtl/slope_vegetation_indices.sv =====
// channel | dir | fields (tdata low bit up)                                  | tuser
// s_      | in  | red[15:0], nir[31:16]                                       | -
// m_      | out | ndvi[15:0] ratio[39:16] tvi[54:40] ctvi[70:55] ttvi[85:71]
//         |     | nratio[101:86], pad[103:102]                                 | invalid_mask[5:0]
// 32 register stages, one pixel per cycle sustained while m_ is not stalled. A pixel taken
// in passes through capture, the 15-stage NDVI divider, the half-offset stage and the
// 15-stage root on its way to m_; the 24-stage ratio divider runs beside them.
// The whole pipeline advances whenever the output register is empty or taken.
// Synchronous active-low reset clears all stage valid bits.
`default_nettype none

module slope_vegetation_indices (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // red, nir
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata,   // ndvi, ratio, tvi, ctvi, ttvi, nratio, pad
    output logic [5:0]        m_tuser    // invalid_mask
);

    localparam int LAST = svi_pkg::NUM_STAGES - 1;

    svi_pkg::stage_t pipe_reg  [svi_pkg::NUM_STAGES];
    svi_pkg::stage_t pipe_next [svi_pkg::NUM_STAGES];

    logic advance;
    assign advance  = !pipe_reg[LAST].valid || m_tready;
    assign s_tready = advance;

    always_comb begin
        logic [15:0]  red;
        logic [15:0]  nir;
        logic [17:0]  ntr;
        logic [16:0]  rtr;
        logic [17:0]  str;
        logic [17:0]  trial;
        logic signed [16:0] h;
        logic [16:0]  habs;
        svi_pkg::stage_t p;
        ntr   = '0;
        rtr   = '0;
        str   = '0;
        trial = '0;
        h     = '0;
        habs  = '0;
        red = s_tdata[15:0];
        nir = s_tdata[31:16];
        p = '0;
        p.valid     = s_tvalid;
        p.both_zero = (red == 16'd0) && (nir == 16'd0);
        p.red_zero  = (red == 16'd0);
        p.nir_zero  = (nir == 16'd0);
        p.nd_neg    = nir < red;
        p.nd_rem    = {2'b00, (nir >= red) ? (nir - red) : (red - nir)};
        p.nd_den    = {1'b0, nir} + {1'b0, red};
        p.rt_den    = red;
        p.rt_num    = {nir, 8'd0};
        pipe_next[0] = p;
        for (int k = 1; k < svi_pkg::NUM_STAGES; k++) begin
            p = pipe_reg[k-1];
            if (k >= svi_pkg::ND_FIRST && k <= svi_pkg::ND_LAST) begin
                ntr = (k == svi_pkg::ND_FIRST) ? p.nd_rem : {p.nd_rem[16:0], 1'b0};
                if (ntr >= {1'b0, p.nd_den}) begin
                    p.nd_rem = ntr - {1'b0, p.nd_den};
                    p.nd_q   = {p.nd_q[13:0], 1'b1};
                end else begin
                    p.nd_rem = ntr;
                    p.nd_q   = {p.nd_q[13:0], 1'b0};
                end
            end
            if (k >= svi_pkg::ND_FIRST && k <= svi_pkg::RT_LAST) begin
                rtr = {p.rt_rem[15:0], p.rt_num[23]};
                p.rt_num = {p.rt_num[22:0], 1'b0};
                if (rtr >= {1'b0, p.rt_den}) begin
                    p.rt_rem = rtr - {1'b0, p.rt_den};
                    p.rt_q   = {p.rt_q[22:0], 1'b1};
                end else begin
                    p.rt_rem = rtr;
                    p.rt_q   = {p.rt_q[22:0], 1'b0};
                end
            end
            if (k == svi_pkg::NDVI_STAGE) begin
                p.ndvi  = p.nd_neg ? -$signed({1'b0, p.nd_q}) : $signed({1'b0, p.nd_q});
                h       = {p.ndvi[15], p.ndvi} + svi_pkg::FRAC_HALF;
                p.h_neg = h[16];
                p.h_le0 = h[16] || (h == 17'sd0);
                habs    = h[16] ? 17'(-h) : 17'(h);
                p.sq_v  = {habs[15:0], 14'd0};
                p.sq_rem  = '0;
                p.sq_root = '0;
            end
            if (k >= svi_pkg::SQ_FIRST && k <= svi_pkg::SQ_LAST) begin
                str   = {p.sq_rem[15:0], p.sq_v[29:28]};
                trial = {1'b0, p.sq_root, 2'b01};
                p.sq_v = {p.sq_v[27:0], 2'b00};
                if (str >= trial) begin
                    p.sq_rem  = str - trial;
                    p.sq_root = {p.sq_root[13:0], 1'b1};
                end else begin
                    p.sq_rem  = str;
                    p.sq_root = {p.sq_root[13:0], 1'b0};
                end
            end
            pipe_next[k] = p;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < svi_pkg::NUM_STAGES; k++) begin
            if (!aresetn) begin
                pipe_reg[k].valid <= 1'b0;
            end else if (advance) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    svi_pkg::stage_t fin;
    logic [15:0] ndvi_o;
    logic [23:0] ratio_o;
    logic [14:0] tvi_o;
    logic [15:0] ctvi_o;
    logic [14:0] ttvi_o;
    logic [15:0] nratio_o;

    assign fin      = pipe_reg[LAST];
    assign ndvi_o   = fin.both_zero ? 16'd0 : fin.ndvi;
    assign ratio_o  = fin.red_zero ? 24'd0 : fin.rt_q;
    assign tvi_o    = (fin.both_zero || fin.h_le0) ? 15'd0 : fin.sq_root;
    assign ttvi_o   = fin.both_zero ? 15'd0 : fin.sq_root;
    assign ctvi_o   = fin.both_zero ? 16'd0 :
                      (fin.h_neg ? 16'(-{1'b0, fin.sq_root}) : {1'b0, fin.sq_root});
    assign nratio_o = fin.nir_zero ? 16'd0 : 16'(-fin.ndvi);

    assign m_tvalid = fin.valid;
    assign m_tdata  = {2'b00, nratio_o, ttvi_o, ctvi_o, tvi_o, ratio_o, ndvi_o};
    assign m_tuser  = {fin.nir_zero, fin.both_zero, fin.both_zero,
                       fin.both_zero || fin.h_le0, fin.red_zero, fin.both_zero};

`ifndef SYNTHESIS
    a_ndvi_zero_when_flagged: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[15:0] == 16'd0)
        else $error("ndvi nonzero while flagged");

    a_tvi_flag_matches_ndvi: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |->
            m_tuser[2] == ($signed(m_tdata[15:0]) <= -16'sd8192))
        else $error("tvi flag disagrees with ndvi");

    a_nratio_mirrors_ndvi: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[5] |-> m_tdata[101:86] == 16'(-m_tdata[15:0]))
        else $error("nratio is not the negated ndvi");

    a_ttvi_matches_tvi: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[2] |-> m_tdata[54:40] == m_tdata[85:71])
        else $error("tvi and ttvi differ on a valid tvi");
`endif

endmodule

`default_nettype wire

// ===== verif/slope_vegetation_indices_test.sv =====
`default_nettype none

module slope_vegetation_indices_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 14;
    localparam longint ONE = 64'd1 << FRAC;
    localparam longint HALF = 64'd1 << (FRAC - 1);

    typedef struct packed {
        logic [5:0]         mask;
        logic signed [15:0] nratio;
        logic [14:0]        ttvi;
        logic signed [15:0] ctvi;
        logic [14:0]        tvi;
        logic [23:0]        ratio;
        logic signed [15:0] ndvi;
    } pixel_idx_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic [5:0]   m_tuser;

    pixel_idx_t expected_idx[$];
    int  errors = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  stall_burst_off = 0;

    slope_vegetation_indices dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("slope_vegetation_indices_test: FAIL");
        $finish;
    end

    // binary search root, fast for 29-bit values
    function automatic longint root_floor(longint v);
        longint lo, hi, mid;
        lo = 0;
        hi = 65536;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (mid * mid <= v) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic longint norm_diff(longint a, longint b);
        longint mag, q;
        mag = (a >= b) ? a - b : b - a;
        q = (mag * ONE) / (a + b);
        return (a >= b) ? q : -q;
    endfunction

    function automatic pixel_idx_t compute_indices(logic [15:0] red, logic [15:0] nir);
        pixel_idx_t p;
        longint r, n, nd, h, root, rt;
        p = '0;
        r = red;
        n = nir;
        if (r + n == 0) begin
            p.mask = 6'h1D;
        end else begin
            nd = norm_diff(n, r);
            p.ndvi = nd[15:0];
            h = nd + HALF;
            root = root_floor((h < 0 ? -h : h) * ONE);
            p.ttvi = root[14:0];
            p.ctvi = (h < 0) ? 16'(-root) : 16'(root);
            if (h <= 0) p.mask[2] = 1'b1;
            else p.tvi = root[14:0];
        end
        if (r == 0) begin
            p.mask[1] = 1'b1;
        end else begin
            rt = (n * 256) / r;
            if (rt > 64'hFFFFFF) rt = 64'hFFFFFF;
            p.ratio = rt[23:0];
        end
        if (n == 0) p.mask[5] = 1'b1;
        else p.nratio = 16'(norm_diff(r, n));
        return p;
    endfunction

    task automatic send_pixel(logic [15:0] red, logic [15:0] nir);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {nir, red};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_idx.push_back(compute_indices(red, nir));
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (stall_burst_off || recv_stall_pct == 0) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        pixel_idx_t got, exp_p;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[101:0]};
            if (expected_idx.size() == 0) begin
                $display("%0t: unexpected transaction %h", $time, got);
                errors++;
            end else begin
                exp_p = expected_idx.pop_front();
                if (got.ndvi !== exp_p.ndvi)
                    $display("%0t: ndvi exp %0d got %0d", $time, exp_p.ndvi, got.ndvi);
                if (got.ratio !== exp_p.ratio)
                    $display("%0t: ratio exp %0d got %0d", $time, exp_p.ratio, got.ratio);
                if (got.tvi !== exp_p.tvi)
                    $display("%0t: tvi exp %0d got %0d", $time, exp_p.tvi, got.tvi);
                if (got.ctvi !== exp_p.ctvi)
                    $display("%0t: ctvi exp %0d got %0d", $time, exp_p.ctvi, got.ctvi);
                if (got.ttvi !== exp_p.ttvi)
                    $display("%0t: ttvi exp %0d got %0d", $time, exp_p.ttvi, got.ttvi);
                if (got.nratio !== exp_p.nratio)
                    $display("%0t: nratio exp %0d got %0d", $time, exp_p.nratio,
                             got.nratio);
                if (got.mask !== exp_p.mask)
                    $display("%0t: invalid_mask exp %h got %h", $time, exp_p.mask,
                             got.mask);
                if (got !== exp_p) errors++;
            end
        end
    end

    task automatic test_corner_pixels();
        send_pixel(16'd0, 16'd0);
        send_pixel(16'd0, 16'd1);
        send_pixel(16'd1, 16'd0);
        send_pixel(16'd0, 16'hFFFF);
        send_pixel(16'hFFFF, 16'd0);
        send_pixel(16'hFFFF, 16'hFFFF);
        send_pixel(16'd1, 16'hFFFF);
        send_pixel(16'hFFFF, 16'd1);
        send_pixel(16'd3, 16'd1);       // ndvi exactly -1/2
        send_pixel(16'd300, 16'd100);
        send_pixel(16'd7, 16'd2);       // ndvi below -1/2
        send_pixel(16'd5, 16'd3);
        send_pixel(16'd1, 16'd1);
        send_pixel(16'h5555, 16'hAAAA);
        send_pixel(16'hAAAA, 16'h5555);
        send_pixel(16'd2, 16'd65535);
        send_pixel(16'd1000, 16'd999);
    endtask

    task automatic test_random_pixels(int count);
        logic [15:0] r, n;
        repeat (count) begin
            case ($urandom_range(3))
                0: begin r = 16'($urandom); n = 16'($urandom); end
                1: begin r = 16'($urandom_range(255)); n = 16'($urandom_range(255)); end
                2: begin
                    r = 16'($urandom);
                    n = 16'(r / 3 + $urandom_range(3));
                end
                default: begin
                    r = $urandom_range(1) ? 16'd0 : 16'($urandom);
                    n = $urandom_range(1) ? 16'd0 : 16'($urandom);
                end
            endcase
            send_pixel(r, n);
        end
    endtask

    task automatic run_phase(int idle, int stall, int count);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        test_random_pixels(count);
    endtask

    task automatic test_idle_mix();
        run_phase(0, 0, 400);
        run_phase(55, 0, 400);
        run_phase(0, 55, 400);
        run_phase(9, 9, 400);
    endtask

    initial begin
        int wait_cycles;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_corner_pixels();
        test_idle_mix();
        s_tvalid <= 1'b0;
        stall_burst_off = 1;
        wait_cycles = 0;
        while (expected_idx.size() != 0 && wait_cycles < 10000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (40) @(posedge aclk);
        if (errors == 0 && expected_idx.size() == 0) begin
            $display("slope_vegetation_indices_test: PASS");
        end else begin
            $display("slope_vegetation_indices_test: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/svi_pkg.sv
hw/rtl/slope_vegetation_indices.sv
verif/slope_vegetation_indices_test.sv
